[sv/ssa_pkg.sv]
// ----------------------------------------------------------------------------
// ssa_pkg: shared types and codes of the spectrum slot allocator
// Request, response and configuration structs, status codes and the item
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int RATE_W      = 20;
  localparam int COUNT_W     = 7;
  localparam int DIV_STEPS   = RATE_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_CHECK   = 2'd0;
  localparam logic [1:0] OP_OCCUPY  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOTS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRAIN = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 7'd64;

  typedef enum logic [2:0] {
    ST_SUCCESS,
    ST_BAD_MODE,
    ST_BAD_SLOT,
    ST_PAST_END,
    ST_BUSY,
    ST_NOT_FOUND,
    ST_ZERO_DEMAND
  } status_t;

  typedef enum logic [1:0] {
    ACT_CHECK,
    ACT_OCCUPY,
    ACT_RELEASE
  } action_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        mode_index;
    logic [5:0]        start_slot;
    logic [RATE_W-1:0] rate_mhz;
  } req_t;

  typedef struct packed {
    logic               passed;
    logic [2:0]         status;
    logic [COUNT_W-1:0] slot_count;
  } resp_t;

  typedef struct packed {
    logic [COUNT_W-1:0] slot_limit;
    logic [RATE_W-1:0]  grain;
  } cfg_view_t;

  typedef struct packed {
    action_t            action;
    logic [1:0]         mode_index;
    logic [5:0]         start_slot;
    logic [RATE_W-1:0]  rate_mhz;
    logic               settled;
    status_t            status;
    logic [COUNT_W-1:0] slot_count;
  } item_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

endpackage

`default_nettype wire

[sv/spectrum_slot_allocator.sv]
// ----------------------------------------------------------------------------
// spectrum_slot_allocator: contiguous spectrum slot allocation
// Checks, occupies and releases runs of slots in per-mode occupancy maps.
//
//   channel  | direction | handshake            | payload
//   cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in       | in        | in_valid/in_ready    | ssa_pkg::req_t
//   out      | out       | out_valid/out_ready  | ssa_pkg::resp_t
//
// A check or occupy request passes the 20-step divider that works out the slot
// count before its response is offered. A release reads the run length memory
// instead, and a request settled in the front end skips both.
// After reset a clearing pass over all MAX_MODES * MAX_SLOTS entries empties
// the run length memory; no request is taken until it ends.
// A two-entry queue takes further requests while the back end is busy or a
// response is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_slot_allocator #(
  parameter int MAX_MODES = 4,
  parameter int MAX_SLOTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ssa_pkg::req_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ssa_pkg::resp_t                  out_data
);
  import ssa_pkg::*;

  logic              init_done;
  qstat_t            qstat;
  logic              push;
  item_t             push_item;
  logic              pop;
  item_t             pop_item;
  cfg_view_t         cfg;
  logic              div_start;
  logic [RATE_W-1:0] div_dividend;
  logic              div_done;
  logic [RATE_W-1:0] div_quo;
  logic              div_rem_nz;

  ssa_front #(
    .MAX_MODES(MAX_MODES),
    .MAX_SLOTS(MAX_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .init_done (init_done),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  ssa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  ssa_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cfg.grain),
    .done     (div_done),
    .quotient (div_quo),
    .rem_nz   (div_rem_nz)
  );

  ssa_back #(
    .MAX_MODES(MAX_MODES),
    .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .q_item       (pop_item),
    .pop          (pop),
    .cfg          (cfg),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_done     (div_done),
    .div_quo      (div_quo),
    .div_rem_nz   (div_rem_nz),
    .init_done    (init_done),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

`ifndef SYNTHESIS
  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !in_ready)
    else $error("request taken during the clearing pass");

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("request pushed into a full queue");

  a_success_has_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.passed) |->
      (out_data.status == ST_SUCCESS && out_data.slot_count != '0 &&
       out_data.slot_count <= COUNT_SAT))
    else $error("successful response without a valid run length");

  a_refusal_has_no_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == ST_BAD_MODE || out_data.status == ST_BAD_SLOT ||
                   out_data.status == ST_ZERO_DEMAND || out_data.status == ST_NOT_FOUND))
      |-> (out_data.slot_count == '0 && !out_data.passed))
    else $error("refused response carries a slot count");
`endif

endmodule

`default_nettype wire

[sv/ssa_front.sv]
// ----------------------------------------------------------------------------
// ssa_front: request intake and classification
// Holds the configuration registers, takes requests and settles those that
// are refused on fields or a zero grain before queueing them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_front #(
  parameter int MAX_MODES = 4,
  parameter int MAX_SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ssa_pkg::req_t                       in_data,
  input  logic                                init_done,
  input  ssa_pkg::qstat_t                     qstat,
  output logic                                push,
  output ssa_pkg::item_t                      push_item,
  output ssa_pkg::cfg_view_t                  cfg
);
  import ssa_pkg::*;

  logic [2:0]         modes_in_use;
  logic [COUNT_W-1:0] slots_in_use;
  logic [RATE_W-1:0]  slot_grain_mhz;
  logic [7:0]         modes_eff;
  logic [7:0]         slots_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modes_in_use   <= 3'd1;
      slots_in_use   <= 7'd1;
      slot_grain_mhz <= 20'd100000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODES: modes_in_use   <= cfg_data[2:0];
        CFG_SLOTS: slots_in_use   <= cfg_data[COUNT_W-1:0];
        CFG_GRAIN: slot_grain_mhz <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign modes_eff = ({5'd0, modes_in_use} > 8'(MAX_MODES)) ? 8'(MAX_MODES)
                                                            : {5'd0, modes_in_use};
  assign slots_eff = ({1'b0, slots_in_use} > 8'(MAX_SLOTS)) ? 8'(MAX_SLOTS)
                                                            : {1'b0, slots_in_use};

  assign cfg.slot_limit = slots_eff[COUNT_W-1:0];
  assign cfg.grain      = slot_grain_mhz;

  assign in_ready = init_done && !qstat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.mode_index = in_data.mode_index;
    push_item.start_slot = in_data.start_slot;
    push_item.rate_mhz   = in_data.rate_mhz;
    push_item.settled    = 1'b0;
    push_item.status     = ST_SUCCESS;
    push_item.slot_count = '0;
    case (in_data.op)
      OP_OCCUPY:  push_item.action = ACT_OCCUPY;
      OP_RELEASE: push_item.action = ACT_RELEASE;
      default:    push_item.action = ACT_CHECK;
    endcase
    if (in_data.op == OP_RELEASE) begin
      if (int'(in_data.mode_index) >= MAX_MODES || int'(in_data.start_slot) >= MAX_SLOTS) begin
        push_item.settled = 1'b1;
        push_item.status  = ST_NOT_FOUND;
      end
    end else if ({6'd0, in_data.mode_index} >= modes_eff) begin
      push_item.settled = 1'b1;
      push_item.status  = ST_BAD_MODE;
    end else if ({2'd0, in_data.start_slot} >= slots_eff) begin
      push_item.settled = 1'b1;
      push_item.status  = ST_BAD_SLOT;
    end else if (in_data.rate_mhz == '0) begin
      push_item.settled = 1'b1;
      push_item.status  = ST_ZERO_DEMAND;
    end else if (slot_grain_mhz == '0) begin
      push_item.settled    = 1'b1;
      push_item.status     = ST_PAST_END;
      push_item.slot_count = COUNT_SAT;
    end
  end

endmodule

`default_nettype wire

[sv/ssa_queue.sv]
// ----------------------------------------------------------------------------
// ssa_queue: two-entry queue between front end and back end
// Lets the front end take the next request while the back end is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ssa_pkg::item_t  push_item,
  input  logic            pop,
  output ssa_pkg::item_t  pop_item,
  output ssa_pkg::qstat_t qstat
);
  import ssa_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign qstat.full      = (fill == CW'(QUEUE_DEPTH));
  assign qstat.not_empty = (fill != '0);
  assign pop_item        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/ssa_divider.sv]
// ----------------------------------------------------------------------------
// ssa_divider: restoring divider for the slot count
// Produces one quotient bit per cycle and flags a non-zero remainder so that
// the caller can round the quotient up.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ssa_pkg::RATE_W-1:0] dividend,
  input  logic [ssa_pkg::RATE_W-1:0] divisor,
  output logic                      done,
  output logic [ssa_pkg::RATE_W-1:0] quotient,
  output logic                      rem_nz
);
  import ssa_pkg::*;

  localparam int SW = $clog2(DIV_STEPS);

  logic [RATE_W:0]   rem;
  logic [RATE_W-1:0] quo;
  logic [SW-1:0]     step;
  logic              running;
  logic [RATE_W:0]   shifted;
  logic [RATE_W+1:0] trial;

  assign shifted  = {rem[RATE_W-1:0], quo[RATE_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, divisor};
  assign quotient = quo;
  assign rem_nz   = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= '0;
        quo     <= dividend;
        step    <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem  <= trial[RATE_W+1] ? shifted : trial[RATE_W:0];
        quo  <= {quo[RATE_W-2:0], !trial[RATE_W+1]};
        step <= step + SW'(1);
        if (step == SW'(DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/ssa_back.sv]
// ----------------------------------------------------------------------------
// ssa_back: request execution
// Holds the busy maps and the run length memory, works out the slot count,
// checks and updates the maps and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_back #(
  parameter int MAX_MODES = 4,
  parameter int MAX_SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ssa_pkg::qstat_t            qstat,
  input  ssa_pkg::item_t             q_item,
  output logic                       pop,
  input  ssa_pkg::cfg_view_t         cfg,
  output logic                       div_start,
  output logic [ssa_pkg::RATE_W-1:0] div_dividend,
  input  logic                       div_done,
  input  logic [ssa_pkg::RATE_W-1:0] div_quo,
  input  logic                       div_rem_nz,
  output logic                       init_done,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ssa_pkg::resp_t             out_data
);
  import ssa_pkg::*;

  localparam int DEPTH = MAX_MODES * MAX_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_FETCH,
    B_RELEASE,
    B_DIVIDE,
    B_CHECK,
    B_FINISH
  } bstate_t;

  bstate_t            state;
  item_t              cur;
  status_t            res_status;
  logic [COUNT_W-1:0] res_count;
  logic [63:0]        res_mask;
  logic [AW-1:0]      clr_idx;
  logic [63:0]        busy_rows [MAX_MODES];
  logic [COUNT_W-1:0] run_len [DEPTH];
  logic [COUNT_W-1:0] mem_rd;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [COUNT_W-1:0] mem_wd;
  logic [AW-1:0]      cur_idx;
  logic [RW-1:0]      cur_row;
  logic [63:0]        row_busy;
  logic               load;
  logic               commit;
  logic [RATE_W:0]    ceil_q;
  logic               over;
  logic [COUNT_W-1:0] chk_count;
  logic [7:0]         end_slot;
  logic [63:0]        chk_mask;
  status_t            chk_status;

  function automatic logic [63:0] run_mask(input logic [5:0] start,
                                           input logic [COUNT_W-1:0] len);
    logic [63:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= COUNT_SAT) begin
      m = '1;
    end else begin
      m = (64'd1 << len) - 64'd1;
    end
    return m << start;
  endfunction

  assign init_done    = (state != B_CLEAR);
  assign pop          = (state == B_IDLE) && qstat.not_empty;
  assign div_start    = pop && !q_item.settled && (q_item.action != ACT_RELEASE);
  assign div_dividend = q_item.rate_mhz;

  assign cur_idx  = AW'(int'(cur.mode_index) * MAX_SLOTS + int'(cur.start_slot));
  assign cur_row  = RW'(cur.mode_index);
  assign row_busy = busy_rows[cur_row];
  assign load     = (state == B_FINISH) && (!out_valid || out_ready);
  assign commit   = load && (res_status == ST_SUCCESS);

  always_comb begin
    ceil_q    = {1'b0, div_quo} + {{RATE_W{1'b0}}, div_rem_nz};
    over      = (ceil_q > (RATE_W + 1)'(64));
    chk_count = over ? COUNT_SAT : ceil_q[COUNT_W-1:0];
    end_slot  = {2'b00, cur.start_slot} + {1'b0, chk_count};
    chk_mask  = run_mask(cur.start_slot, chk_count);
    if (over || (end_slot > {1'b0, cfg.slot_limit})) begin
      chk_status = ST_PAST_END;
    end else if ((row_busy & chk_mask) != '0) begin
      chk_status = ST_BUSY;
    end else begin
      chk_status = ST_SUCCESS;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_idx;
    mem_wd = '0;
    if (state == B_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_idx;
    end else if (commit) begin
      if (cur.action == ACT_OCCUPY) begin
        mem_we = 1'b1;
        mem_wd = res_count;
      end else if (cur.action == ACT_RELEASE) begin
        mem_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      run_len[mem_wa] <= mem_wd;
    end
    mem_rd <= run_len[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_MODES; r++) begin
        busy_rows[r] <= '0;
      end
    end else if (commit) begin
      if (cur.action == ACT_OCCUPY) begin
        busy_rows[cur_row] <= row_busy | res_mask;
      end else if (cur.action == ACT_RELEASE) begin
        busy_rows[cur_row] <= row_busy & ~res_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (qstat.not_empty) begin
            cur        <= q_item;
            res_status <= q_item.status;
            res_count  <= q_item.slot_count;
            res_mask   <= '0;
            if (q_item.settled) begin
              state <= B_FINISH;
            end else if (q_item.action == ACT_RELEASE) begin
              state <= B_FETCH;
            end else begin
              state <= B_DIVIDE;
            end
          end
        end
        B_FETCH: begin
          state <= B_RELEASE;
        end
        B_RELEASE: begin
          if (mem_rd == '0) begin
            res_status <= ST_NOT_FOUND;
            res_count  <= '0;
          end else begin
            res_status <= ST_SUCCESS;
            res_count  <= mem_rd;
            res_mask   <= run_mask(cur.start_slot, mem_rd);
          end
          state <= B_FINISH;
        end
        B_DIVIDE: begin
          if (div_done) begin
            state <= B_CHECK;
          end
        end
        B_CHECK: begin
          res_status <= chk_status;
          res_count  <= chk_count;
          res_mask   <= chk_mask;
          state      <= B_FINISH;
        end
        B_FINISH: begin
          if (load) begin
            out_valid           <= 1'b1;
            out_data.passed     <= (res_status == ST_SUCCESS);
            out_data.status     <= res_status;
            out_data.slot_count <= res_count;
            state               <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/tb_spectrum_slot_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_slot_allocator: self-checking bench for the slot allocator
// A tracker class keeps its own copy of the occupancy rows, the run length
// store and the registers. It predicts the response to every accepted request
// and compares each response field by field. A directed pass covers the
// status codes and the corner settings, then random request streams run under
// changing register settings and four patterns of idling on both channels.
// ----------------------------------------------------------------------------
module tb_spectrum_slot_allocator;
  import ssa_pkg::*;

  localparam int MAX_MODES       = 4;
  localparam int MAX_SLOTS       = 64;
  localparam int MAX_RATE        = 1000000;
  localparam int IDLE_LIMIT      = 5000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int BLOCKS_PER_PASS = 6;
  localparam int ITEMS_PER_BLOCK = 38;
  localparam int MAX_GAP         = 24;

  localparam logic [1:0] OP_RESERVED = 2'd3;

  class allocation_tracker;
    logic [63:0]        busy_rows [MAX_MODES];
    logic [COUNT_W-1:0] run_length [MAX_MODES*MAX_SLOTS];
    logic [2:0]         modes_in_use;
    logic [6:0]         slots_in_use;
    logic [19:0]        slot_grain;
    resp_t              expected_q [$];
    int                 errors;
    int                 requests;
    int                 granted;
    int                 refused;

    function new();
      foreach (busy_rows[i]) busy_rows[i] = '0;
      foreach (run_length[i]) run_length[i] = '0;
      modes_in_use = 3'd1;
      slots_in_use = 7'd1;
      slot_grain   = 20'd100000;
      errors   = 0;
      requests = 0;
      granted  = 0;
      refused  = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_MODES: modes_in_use = value[2:0];
        CFG_SLOTS: slots_in_use = value[6:0];
        CFG_GRAIN: slot_grain   = value[19:0];
        default: ;
      endcase
    endfunction

    function resp_t make_resp(status_t st, longint unsigned count);
      resp_t v;
      v.passed     = (st == ST_SUCCESS);
      v.status     = st;
      v.slot_count = (count > 64) ? COUNT_SAT : COUNT_W'(count);
      return v;
    endfunction

    function logic [63:0] run_mask(int unsigned start, int unsigned len);
      logic [63:0] m;
      m = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
      return m << start;
    endfunction

    function resp_t predict_response(req_t r);
      int unsigned     modes;
      int unsigned     slots;
      int unsigned     mode;
      int unsigned     start;
      int unsigned     idx;
      int unsigned     rec;
      longint unsigned rate;
      longint unsigned grain;
      longint unsigned len;
      int unsigned     cnt;
      logic [63:0]     mask;
      modes = (modes_in_use < MAX_MODES) ? modes_in_use : MAX_MODES;
      slots = (slots_in_use < MAX_SLOTS) ? slots_in_use : MAX_SLOTS;
      mode  = r.mode_index;
      start = r.start_slot;
      rate  = r.rate_mhz;
      grain = slot_grain;
      if (r.op == OP_RELEASE) begin
        idx = mode * MAX_SLOTS + start;
        rec = run_length[idx];
        if (rec == 0) return make_resp(ST_NOT_FOUND, 0);
        busy_rows[mode] &= ~run_mask(start, rec);
        run_length[idx] = '0;
        return make_resp(ST_SUCCESS, rec);
      end
      if (mode >= modes) return make_resp(ST_BAD_MODE, 0);
      if (start >= slots) return make_resp(ST_BAD_SLOT, 0);
      if (rate == 0) return make_resp(ST_ZERO_DEMAND, 0);
      if (grain == 0) return make_resp(ST_PAST_END, 64);
      len = (rate + grain - 1) / grain;
      cnt = (len > 64) ? 64 : int'(len);
      if (start + len > slots) return make_resp(ST_PAST_END, cnt);
      mask = run_mask(start, cnt);
      if ((busy_rows[mode] & mask) != '0) return make_resp(ST_BUSY, cnt);
      if (r.op == OP_OCCUPY) begin
        busy_rows[mode] |= mask;
        run_length[mode * MAX_SLOTS + start] = COUNT_W'(cnt);
      end
      return make_resp(ST_SUCCESS, cnt);
    endfunction

    function void note_request(req_t r);
      resp_t want;
      want = predict_response(r);
      expected_q = {expected_q, want};
      requests++;
    endfunction

    function void check_response(resp_t actual);
      resp_t want;
      if (expected_q.size() == 0) begin
        $error("response with no request outstanding: status %0d, slot_count %0d",
               actual.status, actual.slot_count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (want.passed) granted++;
      else refused++;
      if (actual.passed !== want.passed) begin
        $error("passed mismatch: expected %0d, actual %0d", want.passed, actual.passed);
        errors++;
      end
      if (actual.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, actual.status);
        errors++;
      end
      if (actual.slot_count !== want.slot_count) begin
        $error("slot_count mismatch: expected %0d, actual %0d",
               want.slot_count, actual.slot_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  req_t                   in_data;
  logic                   out_valid;
  logic                   out_ready;
  resp_t                  out_data;

  allocation_tracker tracker;
  int                idle_cycles;
  int                idle_pct;
  int                stall_pct;
  int                settings_count;
  int unsigned       cur_modes;
  int unsigned       cur_slots;
  int unsigned       cur_grain;
  logic [7:0]        occupied_runs [$];

  spectrum_slot_allocator #(
    .MAX_MODES(MAX_MODES),
    .MAX_SLOTS(MAX_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) tracker.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) tracker.note_request(in_data);
      if (out_valid && out_ready) tracker.check_response(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int draw_gap();
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue(input logic [1:0] op, input int mode, input int start, input int rate);
    req_t r;
    r.op         = op;
    r.mode_index = mode[1:0];
    r.start_slot = start[5:0];
    r.rate_mhz   = rate[RATE_W-1:0];
    send_request(r);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_settings(input int unsigned modes, input int unsigned slots,
                                  input int unsigned grain);
    logic [CFG_INDEX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0]  val [3];
    wait_idle();
    idx[0] = CFG_MODES;
    idx[1] = CFG_SLOTS;
    idx[2] = CFG_GRAIN;
    val[0] = CFG_DATA_W'(modes);
    val[1] = CFG_DATA_W'(slots);
    val[2] = CFG_DATA_W'(grain);
    cfg_valid = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index = idx[i];
      cfg_data  = val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
    cur_modes = modes;
    cur_slots = slots;
    cur_grain = grain;
    settings_count++;
  endtask

  task automatic pick_settings(input bit roomy);
    int unsigned m;
    int unsigned s;
    int unsigned g;
    case ($urandom_range(9))
      0: m = 0;
      1: m = 7;
      2: m = 1;
      3: m = 4;
      default: m = $urandom_range(1, 4);
    endcase
    case ($urandom_range(9))
      0: s = 0;
      1: s = 127;
      2: s = 1;
      3, 4: s = 64;
      default: s = $urandom_range(1, 64);
    endcase
    case ($urandom_range(11))
      0: g = 0;
      1: g = 1;
      2: g = MAX_RATE;
      default: g = $urandom_range(1000, 250000);
    endcase
    if (roomy) begin
      m = 4;
      s = 64;
      g = $urandom_range(5000, 200000);
    end
    program_settings(m, s, g);
  endtask

  task automatic random_block(input int count);
    req_t            r;
    int unsigned     roll;
    int unsigned     mode_lim;
    int unsigned     slot_lim;
    int unsigned     pick;
    longint unsigned target;
    logic [7:0]      run_key;
    mode_lim = (cur_modes < 1) ? 1 : (cur_modes > MAX_MODES ? MAX_MODES : cur_modes);
    slot_lim = (cur_slots < 1) ? 1 : (cur_slots > MAX_SLOTS ? MAX_SLOTS : cur_slots);
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 30) r.op = OP_CHECK;
      else if (roll < 65) r.op = OP_OCCUPY;
      else if (roll < 95) r.op = OP_RELEASE;
      else r.op = OP_RESERVED;
      if ($urandom_range(99) < 88) r.mode_index = 2'($urandom_range(mode_lim - 1));
      else r.mode_index = 2'($urandom_range(3));
      if ($urandom_range(99) < 88) r.start_slot = 6'($urandom_range(slot_lim - 1));
      else r.start_slot = 6'($urandom_range(63));
      roll = $urandom_range(99);
      if (roll < 5) begin
        r.rate_mhz = '0;
      end else if (roll < 15 || cur_grain == 0 || cur_grain > 250000) begin
        r.rate_mhz = RATE_W'($urandom_range(1, MAX_RATE));
      end else begin
        target = longint'($urandom_range(1, 6)) * cur_grain;
        target = target - $urandom_range(cur_grain - 1);
        if (target > MAX_RATE) target = MAX_RATE;
        r.rate_mhz = target[RATE_W-1:0];
      end
      if (r.op == OP_OCCUPY) begin
        run_key = {r.mode_index, r.start_slot};
        occupied_runs = {occupied_runs, run_key};
      end else if (r.op == OP_RELEASE && occupied_runs.size() != 0 &&
                   $urandom_range(99) < 75) begin
        pick = $urandom_range(occupied_runs.size() - 1);
        {r.mode_index, r.start_slot} = occupied_runs[pick];
        occupied_runs.delete(pick);
      end
      send_request(r);
    end
  endtask

  initial begin
    tracker        = new();
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    settings_count = 0;
    cur_modes      = 1;
    cur_slots      = 1;
    cur_grain      = 100000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    program_settings(4, 64, 100000);
    issue(OP_CHECK, 0, 0, 100000);
    issue(OP_OCCUPY, 0, 0, 250000);
    issue(OP_CHECK, 0, 1, 1);
    issue(OP_OCCUPY, 1, 63, 1);
    issue(OP_CHECK, 1, 63, 100001);
    issue(OP_CHECK, 2, 10, 0);
    issue(OP_RESERVED, 3, 5, 300000);
    issue(OP_RELEASE, 0, 0, 0);
    issue(OP_RELEASE, 0, 0, MAX_RATE);
    issue(OP_RELEASE, 1, 63, 0);
    issue(OP_OCCUPY, 3, 0, MAX_RATE);

    // Zero grain and register values above the parameters.
    program_settings(7, 127, 0);
    issue(OP_CHECK, 0, 0, 5);
    issue(OP_OCCUPY, 3, 63, 0);
    issue(OP_RELEASE, 3, 0, 0);

    program_settings(0, 0, 1);
    issue(OP_CHECK, 0, 0, 1);
    program_settings(1, 0, 1);
    issue(OP_OCCUPY, 0, 0, 1);
    issue(OP_CHECK, 1, 0, 1);

    // Whole-row runs of 64 slots.
    program_settings(4, 64, 15625);
    issue(OP_OCCUPY, 0, 0, MAX_RATE);
    issue(OP_CHECK, 0, 5, 15625);
    issue(OP_OCCUPY, 2, 0, MAX_RATE);
    issue(OP_RELEASE, 2, 0, 0);
    issue(OP_RELEASE, 0, 0, 0);
    program_settings(4, 64, 1);
    issue(OP_CHECK, 0, 0, MAX_RATE);
    issue(OP_CHECK, 0, 63, 1);

    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      for (int blk = 0; blk < BLOCKS_PER_PASS; blk++) begin
        pick_settings(blk == 0);
        random_block(ITEMS_PER_BLOCK);
      end
    end

    wait_idle();
    $display("Covered %0d requests (%0d granted, %0d refused) over %0d register settings",
             tracker.requests, tracker.granted, tracker.refused, settings_count);
    $display("and four idling patterns on the request and response channels.");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
